// ===== rtl/sha256s_pkg.sv =====
package sha256s_pkg;

  // Fields of one input transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } byte_item_t;

  // Fields of one output transaction.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  localparam logic [7:0] PAD_MARKER = 8'h80;

  localparam logic [31:0] INITIAL_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Round function helpers.
  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Message schedule helpers.
  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== rtl/sha256_stream_hasher.sv =====
// Streaming SHA-256 hasher.
// The byte channel (byte_valid, byte_stall, byte_item) takes one message byte
// per transaction, or an end marker with or without a byte. The digest channel
// (digest_valid, digest_stall, digest_item) returns eight 32-bit words of the
// final hash, word 0 first, with last_word set on word 7.
// While idle the block takes one byte transaction per cycle. The 64th byte of
// a block starts a compression: 64 rounds of the shared round unit, then an
// update step that folds the result into the chaining words; the byte channel
// stalls through both. An end marker starts padding, which writes one pad byte
// per cycle through the same byte path until the final block is full, and runs
// one or two compressions. After the final compression the digest words leave
// at one per cycle while the receiver does not stall; a stalled word holds, and
// the block takes no byte until the last word is delivered. It then starts a
// new message. Reset loads the initial hash values and empties the buffer and
// bit count; the block is ready in the next cycle.
module sha256_stream_hasher (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_valid,
  output logic                      byte_stall,
  input  sha256s_pkg::byte_item_t   byte_item,
  output logic                      digest_valid,
  input  logic                      digest_stall,
  output sha256s_pkg::digest_item_t digest_item
);
  import sha256s_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_EMIT
  } state_t;

  state_t      state;
  logic [31:0] chain [8];
  logic [31:0] work [8];
  logic [31:0] window [16];
  logic [23:0] acc;
  logic [5:0]  fill;
  logic [60:0] byte_count;
  logic [5:0]  round;
  logic [2:0]  word_sel;
  logic        finishing;
  logic        first_pad;
  logic        length_ok;

  logic [63:0] bit_length;
  logic [5:0]  length_shift;
  logic [7:0]  pad_byte;
  logic [7:0]  wr_byte;
  logic        wr_en;
  logic        block_full;
  logic [31:0] sched_next;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] choose;
  logic [31:0] major;

  // Padding byte: marker first, then zeros, then the big-endian bit length.
  assign bit_length   = {byte_count, 3'b000};
  assign length_shift = {~fill[2:0], 3'b000};

  always_comb begin
    if (first_pad) begin
      pad_byte = PAD_MARKER;
    end else if (length_ok && fill >= 6'd56) begin
      pad_byte = bit_length[length_shift +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Byte write path shared by message bytes and padding.
  always_comb begin
    wr_en   = 1'b0;
    wr_byte = byte_item.data_byte;
    case (state)
      ST_IDLE: begin
        wr_en = byte_valid && byte_item.byte_present;
      end
      ST_PAD: begin
        wr_en   = 1'b1;
        wr_byte = pad_byte;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign block_full = wr_en && (fill == 6'd63);

  // Shared round unit: one schedule word and one compression round per cycle.
  always_comb begin
    sched_next = small_sigma1(window[14]) + window[9] + small_sigma0(window[1]) + window[0];
    choose     = (work[4] & work[5]) ^ (~work[4] & work[6]);
    major      = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    t1         = work[7] + big_sigma1(work[4]) + choose + ROUND_CONST[round] + window[0];
    t2         = big_sigma0(work[0]) + major;
  end

  assign byte_stall   = (state != ST_IDLE);
  assign digest_valid = (state == ST_EMIT);

  always_comb begin
    digest_item.digest_word = chain[word_sel];
    digest_item.word_index  = word_sel;
    digest_item.last_word   = (word_sel == 3'd7);
  end

  // Sequencer, buffer and chaining state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= '0;
      byte_count <= '0;
      round      <= '0;
      word_sel   <= '0;
      finishing  <= 1'b0;
      first_pad  <= 1'b0;
      length_ok  <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= INITIAL_HASH[i];
      end
    end else begin
      // A written byte fills the word buffer; every fourth byte shifts a word
      // into the window, and the last byte of a block starts the rounds.
      if (wr_en) begin
        acc  <= {acc[15:0], wr_byte};
        fill <= fill + 6'd1;
        if (fill[1:0] == 2'b11) begin
          for (int i = 0; i < 15; i++) begin
            window[i] <= window[i + 1];
          end
          window[15] <= {acc, wr_byte};
        end
        if (block_full) begin
          state <= ST_ROUND;
          round <= '0;
          for (int i = 0; i < 8; i++) begin
            work[i] <= chain[i];
          end
        end
      end

      case (state)
        ST_IDLE: begin
          if (byte_valid) begin
            if (byte_item.byte_present) begin
              byte_count <= byte_count + 61'd1;
            end
            if (byte_item.end_of_message) begin
              finishing <= 1'b1;
              first_pad <= 1'b1;
              length_ok <= 1'b0;
              if (!block_full) begin
                state <= ST_PAD;
              end
            end
          end
        end

        ST_ROUND: begin
          work[0] <= t1 + t2;
          work[1] <= work[0];
          work[2] <= work[1];
          work[3] <= work[2];
          work[4] <= work[3] + t1;
          work[5] <= work[4];
          work[6] <= work[5];
          work[7] <= work[6];
          for (int i = 0; i < 15; i++) begin
            window[i] <= window[i + 1];
          end
          window[15] <= sched_next;
          round      <= round + 6'd1;
          if (round == 6'd63) begin
            state <= ST_UPDATE;
          end
        end

        ST_UPDATE: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + work[i];
          end
          if (finishing && !first_pad && length_ok) begin
            state    <= ST_EMIT;
            word_sel <= '0;
          end else if (finishing) begin
            state <= ST_PAD;
            if (!first_pad) begin
              length_ok <= 1'b1;
            end
          end else begin
            state <= ST_IDLE;
          end
        end

        ST_PAD: begin
          // The length fits after the marker only if the marker lands early.
          if (first_pad) begin
            first_pad <= 1'b0;
            length_ok <= (fill <= 6'd55);
          end
        end

        ST_EMIT: begin
          if (!digest_stall) begin
            word_sel <= word_sel + 3'd1;
            if (word_sel == 3'd7) begin
              state      <= ST_IDLE;
              finishing  <= 1'b0;
              length_ok  <= 1'b0;
              byte_count <= '0;
              for (int i = 0; i < 8; i++) begin
                chain[i] <= INITIAL_HASH[i];
              end
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
